// File: hdl/tfn_pkg.sv
package tfn_pkg;

  // Input and edge widths
  localparam int COORD_W   = 24;
  localparam int EDGE_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * EDGE_W;
  localparam int NRM_W     = PROD_W + 1;
  localparam int MAG_W     = PROD_W;

  // Leading-one search over the largest magnitude, in groups of eight bits
  localparam int GRP_W     = 8;
  localparam int GRP_N     = (MAG_W + GRP_W - 1) / GRP_W;
  localparam int POS_W     = 3;
  localparam int LEAD_W    = 6;

  // Normalized magnitudes and their square sum
  localparam int NORM_TOP  = 29;
  localparam int U_W       = NORM_TOP + 1;
  localparam int SQ_W      = 2 * U_W;
  localparam int S_W       = SQ_W + 2;

  // Square root chain: one root bit per cell
  localparam int ROOT_W    = S_W / 2;
  localparam int SQ_CELLS  = ROOT_W;
  localparam int REM_W     = ROOT_W + 2;

  // Divider chain: one quotient bit per cell
  localparam int Q_W       = 16;
  localparam int DEN_W     = ROOT_W + 1;
  localparam int DVD_W     = U_W + Q_W + 1;
  localparam int DIV_CELLS = Q_W;

  localparam int OUT_W     = 16;
  localparam logic [Q_W-1:0] Q15_MAX = 16'h7fff;

  typedef struct packed {
    logic signed [COORD_W-1:0] a_x;
    logic signed [COORD_W-1:0] a_y;
    logic signed [COORD_W-1:0] a_z;
    logic signed [COORD_W-1:0] b_x;
    logic signed [COORD_W-1:0] b_y;
    logic signed [COORD_W-1:0] b_z;
    logic signed [COORD_W-1:0] c_x;
    logic signed [COORD_W-1:0] c_y;
    logic signed [COORD_W-1:0] c_z;
  } tri_t;

  // Side data that rides along the square root chain
  typedef struct packed {
    logic [2:0]          neg;
    logic                degen;
    logic [2:0][U_W-1:0] u;
  } carry_t;

  typedef struct packed {
    logic [S_W-1:0]    s;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [2:0]            neg;
    logic                  degen;
    logic [DEN_W-1:0]      den;
    logic [2:0][REM_W-1:0] rem;
    logic [2:0][Q_W-1:0]   x;
  } div_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] nx;
    logic signed [OUT_W-1:0] ny;
    logic signed [OUT_W-1:0] nz;
    logic                    degen;
  } res_t;

endpackage

// File: hdl/tfn_if.sv
interface tfn_tri_if;
  logic valid;
  logic ready;
  logic signed [tfn_pkg::COORD_W-1:0] a_x;
  logic signed [tfn_pkg::COORD_W-1:0] a_y;
  logic signed [tfn_pkg::COORD_W-1:0] a_z;
  logic signed [tfn_pkg::COORD_W-1:0] b_x;
  logic signed [tfn_pkg::COORD_W-1:0] b_y;
  logic signed [tfn_pkg::COORD_W-1:0] b_z;
  logic signed [tfn_pkg::COORD_W-1:0] c_x;
  logic signed [tfn_pkg::COORD_W-1:0] c_y;
  logic signed [tfn_pkg::COORD_W-1:0] c_z;

  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  input ready);
  modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                output ready);
endinterface

interface tfn_nrm_if;
  logic valid;
  logic ready;
  logic signed [tfn_pkg::OUT_W-1:0] normal_x;
  logic signed [tfn_pkg::OUT_W-1:0] normal_y;
  logic signed [tfn_pkg::OUT_W-1:0] normal_z;
  logic                             degenerate;

  modport source (output valid, normal_x, normal_y, normal_z, degenerate,
                  input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, degenerate,
                output ready);
endinterface

// File: hdl/triangle_face_normal_unit.sv
// Triangle face normal unit.
// The tri_i channel takes one beat per triangle: three corners, each with
// signed Q12.12 x, y and z. The nrm_o channel returns one beat per triangle
// with the unit face normal in signed Q1.15 and a degenerate flag that is
// set, with a zero normal, when the cross product is the zero vector.
// A component of exactly +1.0 comes out as 32767.
// Throughput: one triangle per cycle while tri_i.ready is high.
// Path from an accepted input beat to the output beat: 10 front stages
// (edges, products, cross product, maximum, leading one search,
// normalizing shift, squares, sum), a chain of 31 square root
// cells (one root bit each), one divider setup stage, a chain of 16 divider
// cells (one quotient bit each, three lanes) and the output register.
// Every stage moves together. A one-beat skid register behind the output
// register lets the chain keep moving for one more beat when the receiver
// stalls; once the skid is full, tri_i.ready drops until it drains.
// Reset clears all valid flags; no result is pending after reset.
module triangle_face_normal_unit (
  input  logic clk_i,
  input  logic rst_ni,
  tfn_tri_if.sink   tri_i,
  tfn_nrm_if.source nrm_o
);

  logic                    en;
  logic                    front_v;
  logic [tfn_pkg::S_W-1:0] front_sum;
  tfn_pkg::carry_t         front_carry;
  tfn_pkg::tri_t           tri_in;

  logic            sq_v  [tfn_pkg::SQ_CELLS+1];
  tfn_pkg::sqrt_t  sq_st [tfn_pkg::SQ_CELLS+1];
  tfn_pkg::carry_t sq_cr [tfn_pkg::SQ_CELLS+1];

  logic          dv_v [tfn_pkg::DIV_CELLS+1];
  tfn_pkg::div_t dv_st [tfn_pkg::DIV_CELLS+1];
  tfn_pkg::div_t prep_d;
  logic [tfn_pkg::DVD_W-1:0] dvd [3];

  logic          prep_v_q;
  tfn_pkg::div_t prep_q;

  tfn_pkg::res_t res_c;
  tfn_pkg::res_t out_q, skid_q;
  logic          out_v_q, skid_v_q, out_v_d, skid_v_d;
  logic          take;
  logic [tfn_pkg::Q_W-1:0]   qv [3];
  logic [tfn_pkg::OUT_W-1:0] nv [3];

  // Stall the whole chain only while the skid holds a beat
  assign en          = !skid_v_q;
  assign tri_i.ready = en;

  assign tri_in.a_x = tri_i.a_x;
  assign tri_in.a_y = tri_i.a_y;
  assign tri_in.a_z = tri_i.a_z;
  assign tri_in.b_x = tri_i.b_x;
  assign tri_in.b_y = tri_i.b_y;
  assign tri_in.b_z = tri_i.b_z;
  assign tri_in.c_x = tri_i.c_x;
  assign tri_in.c_y = tri_i.c_y;
  assign tri_in.c_z = tri_i.c_z;

  tfn_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (tri_i.valid),
    .tri_i   (tri_in),
    .valid_o (front_v),
    .sum_o   (front_sum),
    .carry_o (front_carry)
  );

  // Seed the square root chain
  assign sq_v[0]       = front_v;
  assign sq_st[0].s    = front_sum;
  assign sq_st[0].rem  = '0;
  assign sq_st[0].root = '0;
  assign sq_cr[0]      = front_carry;

  for (genvar k = 0; k < tfn_pkg::SQ_CELLS; k++) begin : g_sqrt
    tfn_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_v[k]),
      .sqrt_i  (sq_st[k]),
      .carry_i (sq_cr[k]),
      .valid_o (sq_v[k+1]),
      .sqrt_o  (sq_st[k+1]),
      .carry_o (sq_cr[k+1])
    );
  end

  // Build dividends u * 2^16 + r and the divisor 2r
  always_comb begin
    prep_d       = '0;
    prep_d.neg   = sq_cr[tfn_pkg::SQ_CELLS].neg;
    prep_d.degen = sq_cr[tfn_pkg::SQ_CELLS].degen;
    prep_d.den   = {sq_st[tfn_pkg::SQ_CELLS].root, 1'b0};
    for (int l = 0; l < 3; l++) begin
      dvd[l] = {1'b0, sq_cr[tfn_pkg::SQ_CELLS].u[l], {tfn_pkg::Q_W{1'b0}}}
             + tfn_pkg::DVD_W'(sq_st[tfn_pkg::SQ_CELLS].root);
      prep_d.rem[l] = tfn_pkg::REM_W'(dvd[l][tfn_pkg::DVD_W-1:tfn_pkg::Q_W]);
      prep_d.x[l]   = dvd[l][tfn_pkg::Q_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_v_q <= 1'b0;
    end else if (en) begin
      prep_v_q <= sq_v[tfn_pkg::SQ_CELLS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prep_q <= prep_d;
    end
  end

  assign dv_v[0]  = prep_v_q;
  assign dv_st[0] = prep_q;

  for (genvar k = 0; k < tfn_pkg::DIV_CELLS; k++) begin : g_div
    tfn_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_v[k]),
      .div_i   (dv_st[k]),
      .valid_o (dv_v[k+1]),
      .div_o   (dv_st[k+1])
    );
  end

  // Apply signs, saturate +1.0 and zero a degenerate normal
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      qv[l] = dv_st[tfn_pkg::DIV_CELLS].x[l];
      if (dv_st[tfn_pkg::DIV_CELLS].degen) begin
        nv[l] = '0;
      end else if (dv_st[tfn_pkg::DIV_CELLS].neg[l]) begin
        nv[l] = tfn_pkg::OUT_W'(-qv[l]);
      end else begin
        nv[l] = (qv[l] > tfn_pkg::Q15_MAX) ? tfn_pkg::OUT_W'(tfn_pkg::Q15_MAX)
                                           : tfn_pkg::OUT_W'(qv[l]);
      end
    end
    res_c.nx    = nv[0];
    res_c.ny    = nv[1];
    res_c.nz    = nv[2];
    res_c.degen = dv_st[tfn_pkg::DIV_CELLS].degen;
  end

  // Output register with a one-beat skid
  assign take = out_v_q && nrm_o.ready;

  always_comb begin
    out_v_d  = out_v_q;
    skid_v_d = skid_v_q;
    if (en) begin
      if (dv_v[tfn_pkg::DIV_CELLS]) begin
        out_v_d = 1'b1;
        if (out_v_q && !take) begin
          skid_v_d = 1'b1;
        end
      end else if (take) begin
        out_v_d = 1'b0;
      end
    end else if (take) begin
      skid_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (dv_v[tfn_pkg::DIV_CELLS]) begin
        if (!out_v_q || take) begin
          out_q <= res_c;
        end else begin
          skid_q <= res_c;
        end
      end
    end else if (take) begin
      out_q <= skid_q;
    end
  end

  assign nrm_o.valid      = out_v_q;
  assign nrm_o.normal_x   = out_q.nx;
  assign nrm_o.normal_y   = out_q.ny;
  assign nrm_o.normal_z   = out_q.nz;
  assign nrm_o.degenerate = out_q.degen;

endmodule

// File: hdl/tfn_front.sv
module tfn_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  tfn_pkg::tri_t           tri_i,
  output logic                    valid_o,
  output logic [tfn_pkg::S_W-1:0] sum_o,
  output tfn_pkg::carry_t         carry_o
);

  localparam int STAGES = 10;
  localparam int WIDE_W = tfn_pkg::MAG_W + tfn_pkg::NORM_TOP;
  localparam int PAD_W  = tfn_pkg::GRP_N * tfn_pkg::GRP_W;

  logic [STAGES-1:0] vld_q;

  logic signed [tfn_pkg::EDGE_W-1:0] e0_q [3];
  logic signed [tfn_pkg::EDGE_W-1:0] e1_q [3];
  logic signed [tfn_pkg::PROD_W-1:0] p_q [6];

  logic [tfn_pkg::MAG_W-1:0] mag3_q [3];
  logic [tfn_pkg::MAG_W-1:0] mag4_q [3];
  logic [tfn_pkg::MAG_W-1:0] mag5_q [3];
  logic [tfn_pkg::MAG_W-1:0] mag6_q [3];
  logic [tfn_pkg::MAG_W-1:0] mag7_q [3];
  logic [2:0] neg3_q, neg4_q, neg5_q, neg6_q, neg7_q, neg8_q, neg9_q;
  logic [tfn_pkg::MAG_W-1:0] mx01_q, mx_q;

  logic [tfn_pkg::GRP_N-1:0]   nz_q;
  logic [tfn_pkg::POS_W-1:0]   pos_q [tfn_pkg::GRP_N];
  logic [tfn_pkg::LEAD_W-1:0]  lead_q;
  logic                        zero_q;

  logic [tfn_pkg::U_W-1:0]  u8_q [3];
  logic [tfn_pkg::U_W-1:0]  u9_q [3];
  logic [tfn_pkg::SQ_W-1:0] sq_q [3];
  logic                     degen8_q, degen9_q;

  logic [tfn_pkg::S_W-1:0] sum_q;
  tfn_pkg::carry_t         carry_q;

  // Combinational helpers per stage
  logic signed [tfn_pkg::NRM_W-1:0] n_c [3];
  logic signed [tfn_pkg::NRM_W-1:0] na_c [3];
  logic [PAD_W-1:0]                 pad_c;
  logic [tfn_pkg::GRP_N-1:0]        nz_c;
  logic [tfn_pkg::POS_W-1:0]        pos_c [tfn_pkg::GRP_N];
  logic [tfn_pkg::LEAD_W-1:0]       lead_c;
  logic                             zero_c;
  logic [WIDE_W-1:0]                wide_c [3];

  // Advance the valid line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[STAGES-2:0], valid_i};
    end
  end

  // Form the cross product terms from the corner differences
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      n_c[j] = '0;
    end
    n_c[0] = tfn_pkg::NRM_W'(p_q[0]) - tfn_pkg::NRM_W'(p_q[1]);
    n_c[1] = tfn_pkg::NRM_W'(p_q[2]) - tfn_pkg::NRM_W'(p_q[3]);
    n_c[2] = tfn_pkg::NRM_W'(p_q[4]) - tfn_pkg::NRM_W'(p_q[5]);
    for (int j = 0; j < 3; j++) begin
      na_c[j] = n_c[j][tfn_pkg::NRM_W-1] ? -n_c[j] : n_c[j];
    end
  end

  // Locate the top set bit inside each byte group of the maximum
  always_comb begin
    pad_c = PAD_W'(mx_q);
    for (int g = 0; g < tfn_pkg::GRP_N; g++) begin
      nz_c[g]  = |pad_c[g*tfn_pkg::GRP_W +: tfn_pkg::GRP_W];
      pos_c[g] = '0;
      for (int b = 0; b < tfn_pkg::GRP_W; b++) begin
        if (pad_c[g*tfn_pkg::GRP_W + b]) begin
          pos_c[g] = tfn_pkg::POS_W'(b);
        end
      end
    end
  end

  // Pick the highest nonempty group
  always_comb begin
    lead_c = '0;
    zero_c = 1'b1;
    for (int g = 0; g < tfn_pkg::GRP_N; g++) begin
      if (nz_q[g]) begin
        lead_c = tfn_pkg::LEAD_W'(g * tfn_pkg::GRP_W) + tfn_pkg::LEAD_W'(pos_q[g]);
        zero_c = 1'b0;
      end
    end
  end

  // Move the top bit of the maximum to the normalized position
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      wide_c[j] = {mag7_q[j], {tfn_pkg::NORM_TOP{1'b0}}} >> lead_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e0_q[0] <= tfn_pkg::EDGE_W'(tri_i.b_x) - tfn_pkg::EDGE_W'(tri_i.a_x);
      e0_q[1] <= tfn_pkg::EDGE_W'(tri_i.b_y) - tfn_pkg::EDGE_W'(tri_i.a_y);
      e0_q[2] <= tfn_pkg::EDGE_W'(tri_i.b_z) - tfn_pkg::EDGE_W'(tri_i.a_z);
      e1_q[0] <= tfn_pkg::EDGE_W'(tri_i.c_x) - tfn_pkg::EDGE_W'(tri_i.a_x);
      e1_q[1] <= tfn_pkg::EDGE_W'(tri_i.c_y) - tfn_pkg::EDGE_W'(tri_i.a_y);
      e1_q[2] <= tfn_pkg::EDGE_W'(tri_i.c_z) - tfn_pkg::EDGE_W'(tri_i.a_z);

      p_q[0] <= e0_q[1] * e1_q[2];
      p_q[1] <= e0_q[2] * e1_q[1];
      p_q[2] <= e0_q[2] * e1_q[0];
      p_q[3] <= e0_q[0] * e1_q[2];
      p_q[4] <= e0_q[0] * e1_q[1];
      p_q[5] <= e0_q[1] * e1_q[0];

      for (int j = 0; j < 3; j++) begin
        mag3_q[j] <= na_c[j][tfn_pkg::MAG_W-1:0];
        neg3_q[j] <= n_c[j][tfn_pkg::NRM_W-1];
      end

      mag4_q <= mag3_q;
      neg4_q <= neg3_q;
      mx01_q <= (mag3_q[0] > mag3_q[1]) ? mag3_q[0] : mag3_q[1];

      mag5_q <= mag4_q;
      neg5_q <= neg4_q;
      mx_q   <= (mx01_q > mag4_q[2]) ? mx01_q : mag4_q[2];

      mag6_q <= mag5_q;
      neg6_q <= neg5_q;
      nz_q   <= nz_c;
      pos_q  <= pos_c;

      mag7_q <= mag6_q;
      neg7_q <= neg6_q;
      lead_q <= lead_c;
      zero_q <= zero_c;

      for (int j = 0; j < 3; j++) begin
        u8_q[j] <= wide_c[j][tfn_pkg::U_W-1:0];
      end
      neg8_q   <= neg7_q;
      degen8_q <= zero_q;

      for (int j = 0; j < 3; j++) begin
        sq_q[j] <= tfn_pkg::SQ_W'(u8_q[j]) * tfn_pkg::SQ_W'(u8_q[j]);
      end
      u9_q     <= u8_q;
      neg9_q   <= neg8_q;
      degen9_q <= degen8_q;

      sum_q         <= tfn_pkg::S_W'(sq_q[0]) + tfn_pkg::S_W'(sq_q[1])
                     + tfn_pkg::S_W'(sq_q[2]);
      carry_q.neg   <= neg9_q;
      carry_q.degen <= degen9_q;
      for (int j = 0; j < 3; j++) begin
        carry_q.u[j] <= u9_q[j];
      end
    end
  end

  assign valid_o = vld_q[STAGES-1];
  assign sum_o   = sum_q;
  assign carry_o = carry_q;

endmodule

// File: hdl/tfn_sqrt_cell.sv
module tfn_sqrt_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  tfn_pkg::sqrt_t  sqrt_i,
  input  tfn_pkg::carry_t carry_i,
  output logic            valid_o,
  output tfn_pkg::sqrt_t  sqrt_o,
  output tfn_pkg::carry_t carry_o
);

  logic                         valid_q;
  tfn_pkg::sqrt_t               sqrt_q;
  tfn_pkg::carry_t              carry_q;
  tfn_pkg::sqrt_t               sqrt_d;
  logic [tfn_pkg::REM_W-1:0]    rsh;
  logic [tfn_pkg::REM_W-1:0]    trial;
  logic                         ge;

  // Bring down two radicand bits and try the next root bit
  always_comb begin
    rsh    = {sqrt_i.rem[tfn_pkg::REM_W-3:0], sqrt_i.s[tfn_pkg::S_W-1 -: 2]};
    trial  = {sqrt_i.root, 2'b01};
    ge     = (rsh >= trial);
    sqrt_d.s    = {sqrt_i.s[tfn_pkg::S_W-3:0], 2'b00};
    sqrt_d.rem  = ge ? (rsh - trial) : rsh;
    sqrt_d.root = {sqrt_i.root[tfn_pkg::ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sqrt_q  <= sqrt_d;
      carry_q <= carry_i;
    end
  end

  assign valid_o = valid_q;
  assign sqrt_o  = sqrt_q;
  assign carry_o = carry_q;

endmodule

// File: hdl/tfn_div_cell.sv
module tfn_div_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  tfn_pkg::div_t div_i,
  output logic          valid_o,
  output tfn_pkg::div_t div_o
);

  logic                           valid_q;
  tfn_pkg::div_t                  div_q;
  tfn_pkg::div_t                  div_d;
  logic [2:0][tfn_pkg::REM_W-1:0] rsh;
  logic [tfn_pkg::REM_W-1:0]      den;
  logic [2:0]                     ge;

  // Shift in one dividend bit per lane and subtract the divisor when it fits
  always_comb begin
    div_d = div_i;
    den   = tfn_pkg::REM_W'(div_i.den);
    for (int l = 0; l < 3; l++) begin
      rsh[l] = {div_i.rem[l][tfn_pkg::REM_W-2:0], div_i.x[l][tfn_pkg::Q_W-1]};
      ge[l]  = (rsh[l] >= den);
      div_d.rem[l] = ge[l] ? (rsh[l] - den) : rsh[l];
      div_d.x[l]   = {div_i.x[l][tfn_pkg::Q_W-2:0], ge[l]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign valid_o = valid_q;
  assign div_o   = div_q;

endmodule
